@@ sv/rsfc_pkg.sv @@
// rsfc_pkg: shared types, constants and GF(2^8) helpers for the frame corrector
// field polynomial 0x11d, power and log tables built at elaboration
// no dependencies
`default_nettype none

package rsfc_pkg;

  localparam int unsigned DEF_MAX_FRAME_BYTES = 320;
  localparam int unsigned DEF_PARITY_PER_CW   = 24;
  localparam int unsigned DEF_MAX_CORRECT     = 12;

  localparam int unsigned MIN_FRAME = 64;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned VAL_W     = 8;
  localparam int unsigned TOT_W     = 5;
  localparam logic [8:0]  GF_POLY   = 9'h11D;

  localparam logic KIND_CORR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef logic [7:0] gf_tab_t [256];

  typedef struct packed {
    logic             kind;
    logic             sel;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic [TOT_W-1:0] total;
    logic             fail0;
    logic             fail1;
  } dec_item_t;

  function automatic gf_tab_t gen_alog();
    gf_tab_t    t;
    logic [8:0] x;
    x = 9'd1;
    for (int i = 0; i < 256; i++) begin
      t[i] = x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return t;
  endfunction

  localparam gf_tab_t ALOG = gen_alog();

  function automatic gf_tab_t gen_log();
    gf_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'd0;
    end
    for (int i = 0; i < 255; i++) begin
      t[ALOG[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam gf_tab_t LOG = gen_log();

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'd0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        p = p ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY[7:0] : 8'd0);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] l;
    l = LOG[a];
    return (l == 8'd0) ? 8'd1 : ALOG[8'd255 - l];
  endfunction

endpackage

`default_nettype wire

@@ sv/rsfc_gf_mul.sv @@
// rsfc_gf_mul: the shared GF(2^8) multiplier of the decoder
// depends on rsfc_pkg
`default_nettype none

module rsfc_gf_mul (
  input  wire logic [7:0] a_i,
  input  wire logic [7:0] b_i,
  output logic      [7:0] p_o
);
  import rsfc_pkg::*;

  assign p_o = gf_mul(a_i, b_i);

endmodule

`default_nettype wire

@@ sv/rsfc_decoder.sv @@
// rsfc_decoder: sequencer for syndromes, berlekamp-massey, chien search and forney
// on both interleaved codewords; depends on rsfc_pkg and rsfc_gf_mul
`default_nettype none

module rsfc_decoder #(
  parameter int unsigned MAX_FRAME_BYTES = rsfc_pkg::DEF_MAX_FRAME_BYTES,
  parameter int unsigned PARITY_PER_CW   = rsfc_pkg::DEF_PARITY_PER_CW,
  parameter int unsigned MAX_CORRECT     = rsfc_pkg::DEF_MAX_CORRECT,
  localparam int unsigned AW = $clog2(MAX_FRAME_BYTES)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rsfc_pkg::POS_W-1:0]  len_i,
  output logic      [AW-1:0]               rd_addr_o,
  input  wire logic [7:0]                  rd_data_i,
  output logic                             item_valid_o,
  output rsfc_pkg::dec_item_t              item_o,
  input  wire logic                        item_ready_i
);
  import rsfc_pkg::*;

  localparam int unsigned P  = PARITY_PER_CW;
  localparam int unsigned MC = MAX_CORRECT;
  localparam int unsigned IW = $clog2(P + 2);
  localparam int unsigned SW = $clog2(P);
  localparam int unsigned LW = $clog2(P + 1);
  localparam int unsigned CW = $clog2(MC + 1);
  localparam int unsigned RW = (MC > 1) ? $clog2(MC) : 1;

  typedef enum logic [4:0] {
    D_IDLE, D_SYN, D_BM_START, D_BM_DISC, D_BM_INV, D_BM_COEF, D_BM_UPD, D_BM_LEN,
    D_BM_NEXT, D_CHIEN, D_EVAL, D_FN_SETUP, D_FN_LOOP, D_FN_INV, D_FN_MAG, D_FN_OUT,
    D_CW_END, D_STATUS
  } dec_state_e;

  dec_state_e        st_q;
  logic [POS_W-1:0]  len_q;
  logic [7:0]        n_q;
  logic              sel_q;
  logic [7:0]        j_q;
  logic [1:0]        ph_q;
  logic [7:0]        syn_q [P];
  logic [7:0]        lam_q [P+1];
  logic [7:0]        tmp_q [P+1];
  logic [7:0]        bpr_q [P+1];
  logic [7:0]        t_q   [P+1];
  logic [7:0]        om_q  [P];
  logic [IW-1:0]     l_q, m_q, k_q, i_q;
  logic [7:0]        b_q, d_q, coef_q, inv_q;
  logic [8:0]        r_q;
  logic [CW-1:0]     cnt_q, fk_q;
  logic [7:0]        pos_q  [MC];
  logic [7:0]        root_q [MC];
  logic [7:0]        acc_q, dv_q, pw_q, ar_q, mag_q;
  logic              ok_q;
  logic [TOT_W-1:0]  total_q;
  logic [1:0]        fail_q;

  logic [7:0] mul_a, mul_b, mul_p;

  rsfc_gf_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  function automatic logic [9:0] frame_idx(input logic [7:0] j, input logic sel);
    logic [9:0] jj;
    logic [9:0] f;
    jj = 10'(j);
    if (jj < 10'(P)) begin
      f = (sel ? 10'(P) : 10'd0) + jj;
    end else begin
      f = 10'(2 * P) + ((jj - 10'(P)) << 1) + 10'(sel);
    end
    return f;
  endfunction

  logic [9:0] syn_f, out_f;
  logic       syn_in;
  logic [7:0] syn_byte;

  assign syn_f     = frame_idx(j_q, sel_q);
  assign syn_in    = syn_f < 10'(len_q);
  assign syn_byte  = syn_in ? rd_data_i : 8'd0;
  assign rd_addr_o = syn_f[AW-1:0];
  assign out_f     = frame_idx(pos_q[fk_q[RW-1:0]], sel_q);

  logic [7:0] chien_v;
  logic [9:0] chien_s, chien_p;

  always_comb begin
    chien_v = 8'd0;
    for (int j = 0; j <= P; j++) begin
      if (j <= int'(l_q)) begin
        chien_v = chien_v ^ t_q[j];
      end
    end
    chien_s = 10'(r_q) + 10'(n_q) + 10'd254;
    if (chien_s >= 10'd510) begin
      chien_p = chien_s - 10'd510;
    end else if (chien_s >= 10'd255) begin
      chien_p = chien_s - 10'd255;
    end else begin
      chien_p = chien_s;
    end
  end

  logic [IW-1:0] k_m_i, i_m_m;
  assign k_m_i = k_q - i_q;
  assign i_m_m = i_q - m_q;

  always_comb begin
    mul_a = 8'd0;
    mul_b = 8'd0;
    unique case (st_q)
      D_BM_DISC: begin
        mul_a = lam_q[i_q[LW-1:0]];
        mul_b = syn_q[k_m_i[SW-1:0]];
      end
      D_BM_COEF: begin
        mul_a = d_q;
        mul_b = inv_q;
      end
      D_BM_UPD: begin
        mul_a = coef_q;
        mul_b = bpr_q[i_m_m[LW-1:0]];
      end
      D_EVAL: begin
        mul_a = lam_q[i_q[LW-1:0]];
        mul_b = syn_q[k_m_i[SW-1:0]];
      end
      D_FN_LOOP: begin
        unique case (ph_q)
          2'd0: begin
            mul_a = om_q[i_q[SW-1:0]];
            mul_b = pw_q;
          end
          2'd1: begin
            mul_a = lam_q[i_q[LW-1:0]];
            mul_b = pw_q;
          end
          default: begin
            mul_a = pw_q;
            mul_b = ar_q;
          end
        endcase
      end
      D_FN_MAG: begin
        mul_a = acc_q;
        mul_b = inv_q;
      end
      default: begin
        mul_a = 8'd0;
        mul_b = 8'd0;
      end
    endcase
  end

  always_comb begin
    item_valid_o = 1'b0;
    item_o       = '0;
    if (st_q == D_FN_OUT) begin
      item_valid_o = out_f < 10'(len_q);
      item_o.kind  = KIND_CORR;
      item_o.sel   = sel_q;
      item_o.pos   = out_f[POS_W-1:0];
      item_o.val   = mag_q;
    end else if (st_q == D_STATUS) begin
      item_valid_o = 1'b1;
      item_o.kind  = KIND_STATUS;
      item_o.total = total_q;
      item_o.fail0 = fail_q[0];
      item_o.fail1 = fail_q[1];
    end
  end

  logic [9:0] per;
  logic [9:0] n_full;
  assign per    = (10'(len_i) - 10'(2 * P) + 10'd1) >> 1;
  assign n_full = 10'(P) + per;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= D_IDLE;
      sel_q   <= 1'b0;
      ok_q    <= 1'b0;
      total_q <= '0;
      fail_q  <= 2'b11;
    end else begin
      unique case (st_q)
        D_IDLE: begin
          if (start_i) begin
            len_q   <= len_i;
            total_q <= '0;
            fail_q  <= 2'b11;
            sel_q   <= 1'b0;
            if (int'(len_i) < MIN_FRAME || int'(len_i) < 2 * P) begin
              st_q <= D_STATUS;
            end else begin
              n_q  <= (n_full > 10'd255) ? 8'd255 : n_full[7:0];
              j_q  <= 8'd0;
              ph_q <= 2'd0;
              for (int i = 0; i < P; i++) begin
                syn_q[i] <= 8'd0;
              end
              st_q <= D_SYN;
            end
          end
        end
        D_SYN: begin
          if (ph_q == 2'd0) begin
            ph_q <= 2'd1;
          end else begin
            for (int i = 0; i < P; i++) begin
              syn_q[i] <= gf_mul(syn_q[i], ALOG[i]) ^ syn_byte;
            end
            ph_q <= 2'd0;
            if (j_q == n_q - 8'd1) begin
              st_q <= D_BM_START;
            end else begin
              j_q <= j_q + 8'd1;
            end
          end
        end
        D_BM_START: begin
          for (int i = 0; i <= P; i++) begin
            lam_q[i] <= (i == 0) ? 8'd1 : 8'd0;
            bpr_q[i] <= (i == 0) ? 8'd1 : 8'd0;
          end
          l_q  <= '0;
          m_q  <= IW'(1);
          b_q  <= 8'd1;
          k_q  <= '0;
          i_q  <= IW'(1);
          d_q  <= syn_q[0];
          st_q <= D_BM_DISC;
        end
        D_BM_DISC: begin
          if (i_q <= l_q && i_q <= k_q) begin
            d_q <= d_q ^ mul_p;
            i_q <= i_q + IW'(1);
          end else if (d_q == 8'd0) begin
            m_q  <= m_q + IW'(1);
            st_q <= D_BM_NEXT;
          end else begin
            st_q <= D_BM_INV;
          end
        end
        D_BM_INV: begin
          inv_q <= gf_inv(b_q);
          st_q  <= D_BM_COEF;
        end
        D_BM_COEF: begin
          coef_q <= mul_p;
          for (int i = 0; i <= P; i++) begin
            tmp_q[i] <= lam_q[i];
          end
          i_q  <= m_q;
          st_q <= (int'(m_q) > P) ? D_BM_LEN : D_BM_UPD;
        end
        D_BM_UPD: begin
          lam_q[i_q[LW-1:0]] <= lam_q[i_q[LW-1:0]] ^ mul_p;
          if (int'(i_q) == P) begin
            st_q <= D_BM_LEN;
          end else begin
            i_q <= i_q + IW'(1);
          end
        end
        D_BM_LEN: begin
          if ({l_q, 1'b0} <= {1'b0, k_q}) begin
            l_q <= k_q + IW'(1) - l_q;
            for (int i = 0; i <= P; i++) begin
              bpr_q[i] <= tmp_q[i];
            end
            b_q <= d_q;
            m_q <= IW'(1);
          end else begin
            m_q <= m_q + IW'(1);
          end
          st_q <= D_BM_NEXT;
        end
        D_BM_NEXT: begin
          if (int'(k_q) == P - 1) begin
            if (int'(l_q) > MC) begin
              ok_q <= 1'b0;
              st_q <= D_CW_END;
            end else begin
              for (int i = 0; i <= P; i++) begin
                t_q[i] <= lam_q[i];
              end
              r_q   <= '0;
              cnt_q <= '0;
              st_q  <= D_CHIEN;
            end
          end else begin
            k_q  <= k_q + IW'(1);
            d_q  <= syn_q[SW'(k_q + IW'(1))];
            i_q  <= IW'(1);
            st_q <= D_BM_DISC;
          end
        end
        D_CHIEN: begin
          if (int'(cnt_q) == int'(l_q) || r_q == 9'd255) begin
            if (int'(cnt_q) == int'(l_q)) begin
              ok_q <= 1'b1;
              if (l_q == '0) begin
                st_q <= D_CW_END;
              end else begin
                k_q   <= '0;
                i_q   <= '0;
                acc_q <= 8'd0;
                st_q  <= D_EVAL;
              end
            end else begin
              ok_q <= 1'b0;
              st_q <= D_CW_END;
            end
          end else begin
            if (chien_v == 8'd0 && chien_p < 10'(n_q)) begin
              pos_q[cnt_q[RW-1:0]]  <= chien_p[7:0];
              root_q[cnt_q[RW-1:0]] <= r_q[7:0];
              cnt_q <= cnt_q + CW'(1);
            end
            for (int j = 0; j <= P; j++) begin
              t_q[j] <= gf_mul(t_q[j], ALOG[j]);
            end
            r_q <= r_q + 9'd1;
          end
        end
        D_EVAL: begin
          if (i_q <= l_q && i_q <= k_q) begin
            acc_q <= acc_q ^ mul_p;
            i_q   <= i_q + IW'(1);
          end else begin
            om_q[k_q[SW-1:0]] <= acc_q;
            acc_q <= 8'd0;
            i_q   <= '0;
            if (int'(k_q) == P - 1) begin
              fk_q <= '0;
              st_q <= D_FN_SETUP;
            end else begin
              k_q <= k_q + IW'(1);
            end
          end
        end
        D_FN_SETUP: begin
          ar_q  <= ALOG[root_q[fk_q[RW-1:0]]];
          pw_q  <= 8'd1;
          i_q   <= '0;
          ph_q  <= 2'd0;
          acc_q <= 8'd0;
          dv_q  <= 8'd0;
          st_q  <= D_FN_LOOP;
        end
        D_FN_LOOP: begin
          unique case (ph_q)
            2'd0: begin
              if (int'(i_q) < P) begin
                acc_q <= acc_q ^ mul_p;
              end
              ph_q <= 2'd1;
            end
            2'd1: begin
              if (i_q[0] && i_q <= l_q) begin
                dv_q <= dv_q ^ mul_p;
              end
              ph_q <= 2'd2;
            end
            default: begin
              pw_q <= mul_p;
              ph_q <= 2'd0;
              if (int'(i_q) == P) begin
                st_q <= D_FN_INV;
              end else begin
                i_q <= i_q + IW'(1);
              end
            end
          endcase
        end
        D_FN_INV: begin
          inv_q <= (dv_q == 8'd0) ? 8'd0 : gf_inv(dv_q);
          st_q  <= D_FN_MAG;
        end
        D_FN_MAG: begin
          mag_q <= mul_p;
          st_q  <= D_FN_OUT;
        end
        D_FN_OUT: begin
          if (!item_valid_o || item_ready_i) begin
            if (fk_q == cnt_q - CW'(1)) begin
              st_q <= D_CW_END;
            end else begin
              fk_q <= fk_q + CW'(1);
              st_q <= D_FN_SETUP;
            end
          end
        end
        D_CW_END: begin
          if (ok_q) begin
            fail_q[sel_q] <= 1'b0;
            total_q       <= total_q + TOT_W'(cnt_q);
          end
          if (!sel_q) begin
            sel_q <= 1'b1;
            j_q   <= 8'd0;
            ph_q  <= 2'd0;
            for (int i = 0; i < P; i++) begin
              syn_q[i] <= 8'd0;
            end
            st_q <= D_SYN;
          end else begin
            st_q <= D_STATUS;
          end
        end
        D_STATUS: begin
          if (item_ready_i) begin
            st_q <= D_IDLE;
          end
        end
        default: begin
          st_q <= D_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/interleaved_rs_frame_corrector.sv @@
// interleaved_rs_frame_corrector: top level with frame store, input counter and output register
// depends on rsfc_pkg, rsfc_decoder and rsfc_gf_mul
//
// frame bytes come in on the s_axis channel, one item per byte, tlast on the final byte.
// bytes are stored until tlast; bytes beyond MAX_FRAME_BYTES are dropped and flagged.
// after tlast, s_axis_tready stays low while the two interleaved codewords are decoded
// with one shared GF multiplier in berlekamp-massey, the evaluator and forney. on m_axis
// each codeword that decodes gives one correction item per located error inside the frame
// (tuser[0] low), then one status item with tlast high closes the frame.
// while s_axis_tready is high a byte takes one cycle. each codeword is decoded in turn:
// syndromes over the n codeword bytes, then berlekamp-massey, chien search, the evaluator
// and forney once per located error.
// the result register holds one item; while m_axis stalls with it full the decoder
// waits. reset clears the byte count and all control state;
// the frame store needs no clearing.
`default_nettype none

module interleaved_rs_frame_corrector #(
  parameter int unsigned MAX_FRAME_BYTES = rsfc_pkg::DEF_MAX_FRAME_BYTES,
  parameter int unsigned PARITY_PER_CW   = rsfc_pkg::DEF_PARITY_PER_CW,
  parameter int unsigned MAX_CORRECT     = rsfc_pkg::DEF_MAX_CORRECT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // frame_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // frame_position, error_value, errors_total, first_failed, second_failed,
  // frame_overflow
  output logic      [31:0] m_axis_tdata,
  output logic      [1:0]  m_axis_tuser,   // result_kind, codeword_sel
  output logic             m_axis_tlast    // run_end
);
  import rsfc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);

  typedef enum logic {T_IN, T_DEC} top_state_e;

  top_state_e       st_q;
  logic [POS_W-1:0] cnt_q;
  logic             ovf_q;
  logic             start_q;
  logic [7:0]       mem_q [MAX_FRAME_BYTES];
  logic [7:0]       rd_q;
  logic [AW-1:0]    rd_addr;
  logic             m_valid_q;
  logic [31:0]      m_data_q;
  logic [1:0]       m_user_q;
  logic             m_last_q;

  dec_item_t item;
  logic      item_valid;
  logic      out_free;
  logic      in_acc;
  logic      room;

  assign s_axis_tready = (st_q == T_IN);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign room          = int'(cnt_q) < MAX_FRAME_BYTES;
  assign out_free      = !m_valid_q || m_axis_tready;

  rsfc_decoder #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .PARITY_PER_CW   (PARITY_PER_CW),
    .MAX_CORRECT     (MAX_CORRECT)
  ) u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_q),
    .len_i        (cnt_q),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_q),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (out_free)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc && room) begin
      mem_q[cnt_q[AW-1:0]] <= s_axis_tdata;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= T_IN;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      start_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      unique case (st_q)
        T_IN: begin
          if (in_acc) begin
            if (room) begin
              cnt_q <= cnt_q + POS_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (s_axis_tlast) begin
              start_q <= 1'b1;
              st_q    <= T_DEC;
            end
          end
        end
        T_DEC: begin
          if (item_valid && out_free && item.kind == KIND_STATUS) begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
            st_q  <= T_IN;
          end
        end
        default: begin
          st_q <= T_IN;
        end
      endcase
      if (item_valid && out_free) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {7'd0, ovf_q && item.kind, item.fail1, item.fail0, item.total,
                      item.val, item.pos};
        m_user_q  <= {item.sel, item.kind};
        m_last_q  <= item.kind;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire
